// ----- design/lmlt_pkg.sv -----
// ----------------------------------------------------------------------------
// lmlt_pkg
// Shared types, timing constants and helpers for the LCD mode/line timer.
// ----------------------------------------------------------------------------
package lmlt_pkg;

    localparam int unsigned DOT_W   = 10;
    localparam int unsigned LINE_W  = 8;
    localparam int unsigned CYC_W   = 8;
    localparam int unsigned TDATA_W = 16;

    localparam logic [DOT_W-1:0]  HBLANK_LEN  = 10'd204;
    localparam logic [DOT_W-1:0]  OAM_LEN     = 10'd80;
    localparam logic [DOT_W-1:0]  XFER_LEN    = 10'd172;
    localparam logic [DOT_W-1:0]  LINE_LEN    = 10'd456;
    localparam logic [LINE_W-1:0] VBLANK_LINE = 8'd144;
    localparam logic [LINE_W-1:0] FRAME_LINES = 8'd154;

    // Largest quotient of a 10-bit count by the shortest period (1023 / 80).
    localparam int unsigned MAX_QUOT = 12;

    // Width that holds every multiple up to MAX_QUOT times a 10-bit period.
    localparam int unsigned MULT_W = DOT_W + 4;

    // Configuration register indexes.
    localparam logic CFG_LYC        = 1'b0;
    localparam logic CFG_LYC_IRQ_EN = 1'b1;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } lcd_mode_t;

    typedef struct packed {
        logic [DOT_W-1:0]  dot;
        lcd_mode_t         mode;
        logic [LINE_W-1:0] line;
        logic              coincidence;
    } timer_state_t;

    typedef struct packed {
        lcd_mode_t         mode;
        logic [LINE_W-1:0] line;
        logic              coincidence;
        logic              vblank_irq;
        logic              stat_irq;
        logic              draw_line;
        logic              frame_end;
    } step_result_t;

    // Remainder of a 10-bit count by a constant period. Every multiple of the
    // period is compared in parallel; the largest one that fits is taken off.
    function automatic logic [DOT_W-1:0] rem_by(input logic [DOT_W-1:0] x,
                                                input logic [DOT_W-1:0] d);
        logic [MULT_W-1:0] mult;
        logic [MULT_W-1:0] best;
        best = '0;
        for (int unsigned k = 1; k <= MAX_QUOT; k++) begin
            mult = MULT_W'(k * d);
            if (MULT_W'(x) >= mult) begin
                best = mult;
            end
        end
        return DOT_W'(MULT_W'(x) - best);
    endfunction

endpackage

// ----- design/lmlt_step.sv -----
// ----------------------------------------------------------------------------
// lmlt_step
// One step of the mode sequencer: counter add, one mode transition, compare.
// ----------------------------------------------------------------------------
module lmlt_step (
    input  lmlt_pkg::timer_state_t           cur,
    input  logic [lmlt_pkg::CYC_W-1:0]       cycles,
    input  logic [lmlt_pkg::LINE_W-1:0]      lyc,
    input  logic                             lyc_irq_en,
    output lmlt_pkg::timer_state_t           nxt,
    output lmlt_pkg::step_result_t           res
);
    import lmlt_pkg::*;

    logic [DOT_W-1:0]  sum;
    logic [LINE_W-1:0] line_inc;
    logic [LINE_W-1:0] vb_line;
    logic              vblank;
    logic              stat;
    logic              draw;
    logic              wrap;
    logic              coinc;

    assign sum      = cur.dot + DOT_W'(cycles);
    assign line_inc = cur.line + 8'd1;

    always_comb begin
        nxt     = cur;
        nxt.dot = sum;
        vblank  = 1'b0;
        stat    = 1'b0;
        draw    = 1'b0;
        wrap    = 1'b0;
        vb_line = cur.line;
        unique case (cur.mode)
            MODE_HBLANK: begin
                if (sum >= HBLANK_LEN) begin
                    nxt.dot  = rem_by(sum, HBLANK_LEN);
                    nxt.line = line_inc;
                    draw     = 1'b1;
                    stat     = 1'b1;
                    if (line_inc == VBLANK_LINE) begin
                        nxt.mode = MODE_VBLANK;
                        vblank   = 1'b1;
                    end else begin
                        nxt.mode = MODE_OAM;
                    end
                end
            end
            MODE_OAM: begin
                if (sum >= OAM_LEN) begin
                    nxt.dot  = rem_by(sum, OAM_LEN);
                    nxt.mode = MODE_XFER;
                    stat     = 1'b1;
                end
            end
            MODE_XFER: begin
                if (sum >= XFER_LEN) begin
                    nxt.dot  = rem_by(sum, XFER_LEN);
                    nxt.mode = MODE_HBLANK;
                    stat     = 1'b1;
                end
            end
            MODE_VBLANK: begin
                if (sum >= LINE_LEN) begin
                    vb_line = line_inc;
                    nxt.dot = rem_by(sum, LINE_LEN);
                end
                nxt.line = vb_line;
                // The last vblank line rolls the frame over to line zero.
                if (vb_line == FRAME_LINES) begin
                    nxt.line = '0;
                    nxt.dot  = '0;
                    nxt.mode = MODE_OAM;
                    stat     = 1'b1;
                    wrap     = 1'b1;
                end
            end
            default: ;
        endcase

        coinc = (lyc == nxt.line);
        if (!wrap) begin
            nxt.coincidence = coinc;
            if (coinc && lyc_irq_en) begin
                stat = 1'b1;
            end
        end

        res.mode        = nxt.mode;
        res.line        = nxt.line;
        res.coincidence = nxt.coincidence;
        res.vblank_irq  = vblank;
        res.stat_irq    = stat;
        res.draw_line   = draw;
        res.frame_end   = wrap;
    end

endmodule

// ----- design/lcd_mode_line_timer.sv -----
// ----------------------------------------------------------------------------
// lcd_mode_line_timer
// LCD mode sequencer and scan-line counter driven by elapsed-cycle beats.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on the s_ channel carries the number of clock cycles that have
// passed since the previous beat. The block adds it to its dot counter and
// takes at most one mode transition (OAM search, transfer, hblank, vblank),
// then returns one beat on the m_ channel with the new mode, line number,
// the line/lyc coincidence flag and the interrupt and draw requests. The
// beat that wraps the frame back to line zero carries m_tlast.
// A beat passes through the input register, then the result register, on its
// way to the result beat. Throughput is one beat per clock while m_tready
// stays high; the sequencer state is updated in the same cycle as the result
// register is loaded, so back-to-back beats see each other's effect.
// When the receiver stalls, the result register holds and the input register
// still takes one more beat; after that s_tready drops until m_tready rises.
// A synchronous active-low reset empties both registers, clears lyc, the
// interrupt enable, the counter, the line and the coincidence flag, and
// puts the sequencer in OAM search. The user must write lyc and its enable through
// the configuration port only while no beat is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module lcd_mode_line_timer (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wr_data,
    // Input beats.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] cycles
    // Result beats.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [1:0] mode, [9:2] line, [10] coincidence,
                                   // [11] vblank_irq, [12] stat_irq,
                                   // [13] draw_line, [15:14] zero
    output logic        m_tlast    // frame_end
);
    import lmlt_pkg::*;

    // Configuration registers.
    logic [LINE_W-1:0] lyc_reg;
    logic              lyc_irq_en_reg;

    // Input register.
    logic              in_valid_reg;
    logic [CYC_W-1:0]  in_cycles_reg;

    // Sequencer state.
    timer_state_t      state_reg;
    timer_state_t      state_next;

    // Result register.
    logic              out_valid_reg;
    step_result_t      out_reg;
    step_result_t      out_next;

    logic              advance;

    // An item in the input register moves on whenever the result register is
    // free or being emptied this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    lmlt_step u_step (
        .cur        (state_reg),
        .cycles     (in_cycles_reg),
        .lyc        (lyc_reg),
        .lyc_irq_en (lyc_irq_en_reg),
        .nxt        (state_next),
        .res        (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lyc_reg        <= '0;
            lyc_irq_en_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_LYC:        lyc_reg        <= cfg_wr_data;
                CFG_LYC_IRQ_EN: lyc_irq_en_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_cycles_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.dot         <= '0;
            state_reg.mode        <= MODE_OAM;
            state_reg.line        <= '0;
            state_reg.coincidence <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.draw_line, out_reg.stat_irq, out_reg.vblank_irq,
                       out_reg.coincidence, out_reg.line, out_reg.mode};
    assign m_tlast  = out_reg.frame_end;

endmodule
